/* design/ifir_pkg.sv */
// Shared types and constants for the integer FIR filter.
// Field widths, operation and register codes, and the divider request/response structs.
// No dependencies; ifir_if, ifir_div and integer_fir_filter refer to this package.
package ifir_pkg;

   localparam int SAMPLE_WIDTH       = 16;
   localparam int COEF_WIDTH         = 16;
   localparam int RESULT_WIDTH       = 32;
   localparam int TAP_COUNT_WIDTH    = 9;
   localparam int DENOM_WIDTH        = 16;
   localparam int COEF_INDEX_WIDTH   = 8;
   localparam int CSR_INDEX_WIDTH    = 8;
   localparam int CSR_DATA_WIDTH     = 16;

   // The divider retires this many quotient bits per clock.
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = RESULT_WIDTH / DIV_BITS_PER_CYCLE;
   localparam int DIV_COUNT_WIDTH    = $clog2(DIV_CYCLES);

   typedef logic [1:0] op_type;

   localparam op_type OP_FILTER = 2'd0;
   localparam op_type OP_COEF   = 2'd1;
   localparam op_type OP_CLEAR  = 2'd2;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_TAP_COUNT   = 8'd0;
   localparam csr_index_type REG_DENOMINATOR = 8'd1;

   typedef struct packed {
      logic                           start;
      logic signed [RESULT_WIDTH-1:0] dividend;
      logic [DENOM_WIDTH-1:0]         divisor;
   } div_req_type;

   typedef struct packed {
      logic                           done;
      logic signed [RESULT_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

/* design/ifir_if.sv */
// Valid/ready channel interfaces of the integer FIR filter: request, response, register write.
// Depends on ifir_pkg for the field widths and codes.
interface ifir_req_if;
   logic                                   valid;
   logic                                   ready;
   ifir_pkg::op_type                       op;
   logic signed [ifir_pkg::SAMPLE_WIDTH-1:0] sample;
   logic [ifir_pkg::COEF_INDEX_WIDTH-1:0]  coef_index;
   logic signed [ifir_pkg::COEF_WIDTH-1:0] coef_value;

   modport source (output valid, op, sample, coef_index, coef_value, input ready);
   modport sink   (input valid, op, sample, coef_index, coef_value, output ready);
endinterface

interface ifir_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [ifir_pkg::RESULT_WIDTH-1:0] filtered_sample;

   modport source (output valid, filtered_sample, input ready);
   modport sink   (input valid, filtered_sample, output ready);
endinterface

interface ifir_csr_if;
   logic                                  valid;
   logic                                  ready;
   ifir_pkg::csr_index_type               index;
   logic [ifir_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/ifir_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module ifir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

/* design/ifir_div.sv */
// Iterative signed divider: 32-bit dividend by a positive 16-bit divisor, quotient
// truncated toward zero, four quotient bits per clock. Depends on ifir_pkg.
module ifir_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ifir_pkg::div_req_type req_in,
   output ifir_pkg::div_rsp_type rsp_out
);

   localparam int RW = ifir_pkg::RESULT_WIDTH;
   localparam int DW = ifir_pkg::DENOM_WIDTH;
   localparam int CW = ifir_pkg::DIV_COUNT_WIDTH;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;

   logic [RW-1:0] step_quo;
   logic [DW-1:0] step_rem;
   logic [DW:0]   trial;

   // Restoring division: the dividend shifts out of the top of quo_ff while
   // quotient bits shift in at the bottom.
   always_comb begin
      step_quo = quo_ff;
      step_rem = rem_ff;
      trial    = '0;
      for (int k = 0; k < ifir_pkg::DIV_BITS_PER_CYCLE; k++) begin
         trial    = {step_rem, step_quo[RW-1]};
         step_quo = {step_quo[RW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial       = trial - {1'b0, dvs_ff};
            step_quo[0] = 1'b1;
         end
         step_rem = trial[DW-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req_in.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = req_in.dividend[RW-1];
         quo_in  = req_in.dividend[RW-1] ? RW'(-req_in.dividend) : RW'(req_in.dividend);
         rem_in  = '0;
         dvs_in  = req_in.divisor;
      end else if (busy_ff) begin
         quo_in = step_quo;
         rem_in = step_rem;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ifir_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // The product sign alone sets the quotient sign, since the divisor is positive.
   assign rsp_out.done     = done_ff;
   assign rsp_out.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

/* design/integer_fir_filter.sv */
// Integer FIR filter, direct form. A filter item (op 0) returns one result, and no new
// request is accepted until that result is registered for rsp_ch. Per tap, S_READ reads the
// coefficient and history RAMs, S_MUL multiplies, and S_START and S_DIV run the shared
// divider that truncates each product by the denominator (four quotient bits per cycle);
// the divider sets the pace. The result is held back while an earlier result still waits
// on rsp_ch. A coefficient write (op 1) completes on accept and leaves the filter idle; a
// history clear (op 2) sweeps every slot of the history RAM to zero, and the same sweep runs
// once after reset, so req_ch.ready first rises when that sweep ends. Coefficients read as
// undefined until written. Depends on ifir_pkg, ifir_if, ifir_ram and ifir_div.
module integer_fir_filter #(
   parameter int MAX_TAPS = 256
) (
   input logic        clock,
   input logic        reset,
   ifir_req_if.sink   req_ch,
   ifir_rsp_if.source rsp_ch,
   ifir_csr_if.sink   csr_ch
);

   localparam int AW = $clog2(MAX_TAPS);
   localparam int TW = $clog2(MAX_TAPS + 1);
   localparam int SW = ifir_pkg::SAMPLE_WIDTH;
   localparam int RW = ifir_pkg::RESULT_WIDTH;
   localparam int DW = ifir_pkg::DENOM_WIDTH;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_START = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [ifir_pkg::TAP_COUNT_WIDTH-1:0] tap_count_ff, tap_count_in;
   logic [DW-1:0]                        denominator_ff, denominator_in;

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [AW-1:0]        wp_ff, wp_in;
   logic [TW-1:0]        tap_ff, tap_in;
   logic [TW-1:0]        taps_ff, taps_in;
   logic [DW-1:0]        dvs_ff, dvs_in;
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [RW-1:0] prod_ff, prod_in;
   logic signed [RW-1:0] sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [RW-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 coef_ok;
   logic [31:0]          tc_wide;
   logic [TW-1:0]        eff_taps;
   logic [TW-1:0]        tap_next;
   logic [AW:0]          slot_diff;
   logic [AW:0]          slot_wrap;
   logic [AW-1:0]        slot;
   logic signed [SW-1:0] coef_rdata;
   logic signed [SW-1:0] hist_rdata;
   logic signed [SW-1:0] tap_sample;

   logic                 coef_we;
   logic                 hist_we;
   logic [AW-1:0]        hist_waddr;
   logic [SW-1:0]        hist_wdata;

   ifir_pkg::div_req_type div_req;
   ifir_pkg::div_rsp_type div_rsp;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign coef_ok  = 32'(req_ch.coef_index) < 32'(MAX_TAPS);

   // Register port: always ready, registers written whole.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      tap_count_in   = tap_count_ff;
      denominator_in = denominator_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            ifir_pkg::REG_TAP_COUNT: begin
               tap_count_in = csr_ch.data[ifir_pkg::TAP_COUNT_WIDTH-1:0];
            end
            ifir_pkg::REG_DENOMINATOR: begin
               denominator_in = csr_ch.data[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Zero taps means one, and the count saturates at the history depth.
   assign tc_wide  = 32'(tap_count_ff);
   assign eff_taps = (tc_wide == 32'd0) ? TW'(1) :
                     (tc_wide > 32'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(tc_wide);
   assign tap_next = TW'(tap_ff + 1'b1);

   // History slot of tap i: write pointer minus i, modulo the depth.
   assign slot_diff = {1'b0, wp_ff} - {1'b0, tap_ff[AW-1:0]};
   assign slot_wrap = slot_diff[AW] ? (slot_diff + (AW+1)'(MAX_TAPS)) : slot_diff;
   assign slot      = slot_wrap[AW-1:0];

   assign tap_sample = (tap_ff == '0) ? x_ff : hist_rdata;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      tap_in       = tap_ff;
      taps_in      = taps_ff;
      dvs_in       = dvs_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = dvs_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_TAPS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_ch.op)
                  ifir_pkg::OP_FILTER: begin
                     x_in     = req_ch.sample;
                     tap_in   = '0;
                     taps_in  = eff_taps;
                     dvs_in   = (denominator_ff == '0) ? DW'(1) : denominator_ff;
                     sum_in   = '0;
                     state_in = S_READ;
                  end
                  ifir_pkg::OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = RW'(coef_rdata) * RW'(tap_sample);
            state_in = S_START;
         end
         S_START: begin
            div_req.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               sum_in = sum_ff + div_rsp.quotient;
               tap_in = tap_next;
               if (tap_next == taps_ff) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_WRITE: begin
            wp_in    = (wp_ff == AW'(MAX_TAPS - 1)) ? '0 : AW'(wp_ff + 1'b1);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign coef_we    = req_fire && (req_ch.op == ifir_pkg::OP_COEF) && coef_ok;
   assign hist_we    = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
   assign hist_waddr = (state_ff == S_CLEAR) ? clr_ff : wp_ff;
   assign hist_wdata = (state_ff == S_CLEAR) ? '0 : x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff   <= ifir_pkg::TAP_COUNT_WIDTH'(1);
         denominator_ff <= DW'(1);
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         wp_ff          <= '0;
         tap_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tap_count_ff   <= tap_count_in;
         denominator_ff <= denominator_in;
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         wp_ff          <= wp_in;
         tap_ff         <= tap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      taps_ff     <= taps_in;
      dvs_ff      <= dvs_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.filtered_sample = rsp_data_ff;

   ifir_ram #(
      .WIDTH (ifir_pkg::COEF_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock      (clock),
      .write_en   (coef_we),
      .write_addr (AW'(req_ch.coef_index)),
      .write_data (req_ch.coef_value),
      .read_addr  (tap_ff[AW-1:0]),
      .read_data  (coef_rdata)
   );

   ifir_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock      (clock),
      .write_en   (hist_we),
      .write_addr (hist_waddr),
      .write_data (hist_wdata),
      .read_addr  (slot),
      .read_data  (hist_rdata)
   );

   ifir_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req_in  (div_req),
      .rsp_out (div_rsp)
   );

endmodule
